// ===== rtl/mlgp_pkg.sv =====
// Shared types and constants for the letter grid path block.
package mlgp_pkg;

  localparam int LETTER_W = 5;
  localparam int SIZE_W = 6;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd32;

  typedef struct packed {
    logic [LETTER_W-1:0] path_letter;
    logic                last_letter;
  } res_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_DRAIN,
    B_EMIT
  } back_state_t;

endpackage

// ===== rtl/mlgp_fifo.sv =====
// Small synchronous FIFO used for the job queue and the result queue.
module mlgp_fifo #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             full,
  output logic             empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      store[wr_ptr] <= wr_data;
    end
  end

endmodule

// ===== rtl/mlgp_front.sv =====
// Front end: accepts grid cells, holds the size register and issues walk jobs.
module mlgp_front
  import mlgp_pkg::*;
#(
  parameter int MAX_SIZE = 32,
  parameter int RW = 5,
  parameter int AW = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [LETTER_W-1:0] cell_letter,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [SIZE_W-1:0]   cfg_data,
  input  logic                job_done,
  output logic                job_push,
  output logic [SIZE_W-1:0]   job_n,
  output logic                mem_we,
  output logic [AW-1:0]       mem_addr,
  output logic [LETTER_W-1:0] mem_data
);
  logic [SIZE_W-1:0] grid_size;
  logic [SIZE_W-1:0] n_use;
  logic [RW-1:0]     row;
  logic [RW-1:0]     col;
  logic              busy;
  logic              accept;
  logic              col_end;
  logic              row_end;

  always_comb begin
    if (grid_size == '0) begin
      n_use = SIZE_W'(1);
    end else if (grid_size > SIZE_W'(MAX_SIZE)) begin
      n_use = SIZE_W'(MAX_SIZE);
    end else begin
      n_use = grid_size;
    end
  end

  assign full      = busy;
  assign cfg_ready = 1'b1;
  assign accept    = push && !busy;
  assign col_end   = (SIZE_W'(col) == n_use - 1'b1);
  assign row_end   = (SIZE_W'(row) == n_use - 1'b1);
  assign mem_we    = accept;
  assign mem_addr  = AW'(32'(row) * MAX_SIZE + 32'(col));
  assign mem_data  = cell_letter;
  assign job_push  = accept && col_end && row_end;
  assign job_n     = n_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size <= SIZE_RESET;
      row       <= '0;
      col       <= '0;
      busy      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        grid_size <= cfg_data;
        row       <= '0;
        col       <= '0;
      end else if (accept) begin
        if (col_end) begin
          col <= '0;
          row <= row_end ? '0 : row + 1'b1;
        end else begin
          col <= col + 1'b1;
        end
      end
      if (job_push) begin
        busy <= 1'b1;
      end else if (job_done) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/mlgp_back.sv =====
// Back end: grid memory and the anti-diagonal walk that produces the path.
module mlgp_back
  import mlgp_pkg::*;
#(
  parameter int MAX_SIZE = 32,
  parameter int RW = 5,
  parameter int AW = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                mem_we,
  input  logic [AW-1:0]       mem_addr,
  input  logic [LETTER_W-1:0] mem_data,
  input  logic                job_empty,
  input  logic [SIZE_W-1:0]   job_n,
  output logic                job_pop,
  input  logic                res_full,
  output logic                res_push,
  output res_t                res_data,
  output logic                job_done,
  output logic                busy
);
  logic [LETTER_W-1:0] mem [MAX_SIZE * MAX_SIZE];
  logic [LETTER_W-1:0] rdata;
  logic [LETTER_W-1:0] diag_val [MAX_SIZE];
  logic [MAX_SIZE-1:0] cur_mark;
  logic [MAX_SIZE-1:0] mark_next;
  back_state_t         state;
  back_state_t         state_next;
  logic [SIZE_W-1:0]   n;
  logic [SIZE_W-1:0]   d;
  logic [RW-1:0]       r;
  logic [RW-1:0]       rd_row;
  logic                rd_valid;
  logic                rd_en;
  logic [LETTER_W-1:0] best;
  logic                found;
  logic [SIZE_W-1:0]   hi;
  logic [SIZE_W:0]     d_plus2;
  logic [SIZE_W:0]     lo_next;
  logic                is_last;
  logic                at_hi;
  logic [AW-1:0]       raddr;

  assign hi      = ((SIZE_W + 1)'(d) + 1'b1 < (SIZE_W + 1)'(n)) ? d : n - 1'b1;
  assign at_hi   = (SIZE_W'(r) == hi);
  assign d_plus2 = (SIZE_W + 1)'(d) + (SIZE_W + 1)'(2);
  assign lo_next = (d_plus2 > (SIZE_W + 1)'(n)) ? d_plus2 - (SIZE_W + 1)'(n) : '0;
  assign is_last = (d_plus2 == {n, 1'b0});
  assign raddr   = AW'(32'(r) * MAX_SIZE + 32'(d - SIZE_W'(r)));

  always_comb begin
    logic down_src;
    logic right_src;
    mark_next = '0;
    for (int i = 0; i < MAX_SIZE; i++) begin
      down_src  = 1'b0;
      if (i > 0) begin
        down_src = cur_mark[i-1] && (diag_val[i-1] == best)
                   && ((SIZE_W + 1)'(i) < (SIZE_W + 1)'(n));
      end
      right_src = cur_mark[i] && (diag_val[i] == best)
                  && ((SIZE_W + 2)'(d) + 1'b1 < (SIZE_W + 2)'(n) + (SIZE_W + 2)'(i));
      mark_next[i] = found && (down_src || right_src);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: begin
        if (!job_empty) state_next = B_READ;
      end
      B_READ: begin
        if (at_hi) state_next = B_DRAIN;
      end
      B_DRAIN: begin
        state_next = B_EMIT;
      end
      B_EMIT: begin
        if (!res_full) state_next = is_last ? B_IDLE : B_READ;
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    job_pop  = (state == B_IDLE) && !job_empty;
    rd_en    = (state == B_READ);
    res_push = (state == B_EMIT) && !res_full;
    job_done = res_push && is_last;
    busy     = (state != B_IDLE);
    res_data.path_letter = best;
    res_data.last_letter = is_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_IDLE;
      rd_valid <= 1'b0;
    end else begin
      state    <= state_next;
      rd_valid <= rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      n        <= job_n;
      d        <= '0;
      r        <= '0;
      cur_mark <= MAX_SIZE'(1);
      found    <= 1'b0;
      best     <= '0;
    end else begin
      if (rd_en) begin
        rd_row <= r;
        if (!at_hi) r <= r + 1'b1;
      end
      if (rd_valid) begin
        diag_val[rd_row] <= rdata;
        if (cur_mark[rd_row] && (!found || rdata < best)) begin
          best  <= rdata;
          found <= 1'b1;
        end
      end
      if (res_push) begin
        cur_mark <= mark_next;
        d        <= d + 1'b1;
        r        <= RW'(lo_next);
        found    <= 1'b0;
        best     <= '0;
      end
    end
  end

endmodule

// ===== rtl/min_letter_grid_path.sv =====
// Top level: smallest right/down letter path through a square letter grid.
// Cells load at one per cycle while full is low; full rises after the last cell of a grid.
// The walk picks up the grid from the job queue, then reads each anti-diagonal, drains the
// last read and emits its smallest marked letter; input is held off until the walk ends.
// The grid memory read port paces the walk; a four-entry result queue absorbs short pop stalls.
// Synchronous reset clears control state and sets the size to 32; memory is not cleared.
module min_letter_grid_path
  import mlgp_pkg::*;
#(
  parameter int MAX_SIZE = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [LETTER_W-1:0] cell_letter,
  output logic                empty,
  input  logic                pop,
  output logic [LETTER_W-1:0] path_letter,
  output logic                last_letter,
  input  logic                grid_size_valid,
  output logic                grid_size_ready,
  input  logic [SIZE_W-1:0]   grid_size
);
  localparam int RW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int AW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE * MAX_SIZE) : 1;

  logic                job_push;
  logic [SIZE_W-1:0]   job_n_in;
  logic [SIZE_W-1:0]   job_n_out;
  logic                job_pop;
  logic                job_full;
  logic                job_empty;
  logic                job_done;
  logic                mem_we;
  logic [AW-1:0]       mem_addr;
  logic [LETTER_W-1:0] mem_data;
  logic                res_push;
  res_t                res_in;
  res_t                res_out;
  logic                res_full;
  logic                back_busy;
  logic                front_full;

  assign full        = front_full || job_full;
  assign path_letter = res_out.path_letter;
  assign last_letter = res_out.last_letter;

  mlgp_front #(
    .MAX_SIZE(MAX_SIZE),
    .RW(RW),
    .AW(AW)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .push(push && !job_full),
    .full(front_full),
    .cell_letter(cell_letter),
    .cfg_valid(grid_size_valid),
    .cfg_ready(grid_size_ready),
    .cfg_data(grid_size),
    .job_done(job_done),
    .job_push(job_push),
    .job_n(job_n_in),
    .mem_we(mem_we),
    .mem_addr(mem_addr),
    .mem_data(mem_data)
  );

  mlgp_fifo #(
    .WIDTH(SIZE_W),
    .DEPTH(2)
  ) u_job_q (
    .clk(clk),
    .rst(rst),
    .wr_en(job_push),
    .wr_data(job_n_in),
    .rd_en(job_pop),
    .rd_data(job_n_out),
    .full(job_full),
    .empty(job_empty)
  );

  mlgp_back #(
    .MAX_SIZE(MAX_SIZE),
    .RW(RW),
    .AW(AW)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .mem_we(mem_we),
    .mem_addr(mem_addr),
    .mem_data(mem_data),
    .job_empty(job_empty),
    .job_n(job_n_out),
    .job_pop(job_pop),
    .res_full(res_full),
    .res_push(res_push),
    .res_data(res_in),
    .job_done(job_done),
    .busy(back_busy)
  );

  mlgp_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(4)
  ) u_res_q (
    .clk(clk),
    .rst(rst),
    .wr_en(res_push),
    .wr_data(res_in),
    .rd_en(pop),
    .rd_data(res_out),
    .full(res_full),
    .empty(empty)
  );

`ifndef SYNTH
  a_busy_blocks_input: assert property (@(posedge clk) disable iff (rst)
    back_busy |-> full)
    else $error("input accepted while the walk is running");

  a_res_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result queue written while full");

  a_single_job: assert property (@(posedge clk) disable iff (rst)
    job_push |-> (job_empty && !back_busy))
    else $error("new grid completed while a walk is pending");

  a_no_write_during_walk: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> !back_busy)
    else $error("grid memory written during the walk");
`endif

endmodule
